[src/command_line_tokenizer_macros.svh]
// assertion macros shared by the tokenizer modules
`ifndef COMMAND_LINE_TOKENIZER_MACROS_SVH
`define COMMAND_LINE_TOKENIZER_MACROS_SVH

// same-cycle implication, checked on clk with reset masked
`define CLT_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/clt_pkg.sv]
// shared types, character codes and classifiers for the tokenizer
`default_nettype none
package clt_pkg;

  localparam int LEXEME_BYTES_DEF = 32;

  typedef enum logic [3:0] {
    KIND_END     = 4'd0,
    KIND_NEWLINE = 4'd1,
    KIND_GT      = 4'd2,
    KIND_GTGT    = 4'd3,
    KIND_PUNCT   = 4'd4,
    KIND_SYMBOL  = 4'd5,
    KIND_NUMBER  = 4'd6,
    KIND_STRING  = 4'd7,
    KIND_INVALID = 4'd8
  } kind_t;

  typedef enum logic [1:0] {
    SERR_NONE    = 2'd0,
    SERR_NEWLINE = 2'd1,
    SERR_EOF     = 2'd2
  } serr_t;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // command from controller to datapath
  typedef struct packed {
    logic load;      // latch the incoming request
    logic scan;      // one scan action on the current character
    logic sel_bs;    // scan a backslash instead of the latched character
    logic fin;       // close the token in progress at end of input
    logic fin_end;   // emit the end token
    logic rd_first;  // start reading the lexeme
    logic rd_next;   // advance to the next lexeme byte
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic consumed;  // scan action used up its character
    logic emit;      // a token is ready to go out
    logic last;      // current output byte is the final one
  } sts_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_octal(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h37;
  endfunction

  // space tab vt ff cr
  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};
  endfunction

  // | . ( ) [ ] { } : , =
  function automatic logic is_punct(input logic [7:0] c);
    return c inside {8'h7C, 8'h2E, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D,
                     8'h3A, 8'h2C, 8'h3D};
  endfunction

  // _ $ / * ?
  function automatic logic is_sym_first(input logic [7:0] c);
    return is_alpha(c) || (c inside {8'h5F, 8'h24, 8'h2F, 8'h2A, 8'h3F});
  endfunction

  function automatic logic is_sym_more(input logic [7:0] c);
    return is_sym_first(c) || is_digit(c) || (c == CH_DASH);
  endfunction

  // digits and + - . e E
  function automatic logic is_num_more(input logic [7:0] c);
    return is_digit(c) || (c inside {8'h2B, 8'h2D, 8'h2E, 8'h65, 8'h45});
  endfunction

endpackage
`default_nettype wire

[src/clt_ram.sv]
// generic single-write, registered-read RAM
`default_nettype none
module clt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[src/clt_dp.sv]
// tokenizer datapath: scan phase, lexeme buffer and token output
`default_nettype none
`include "command_line_tokenizer_macros.svh"
module clt_dp #(
  parameter int LEXEME_BYTES = clt_pkg::LEXEME_BYTES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic [7:0]   in_char_in,
  input  wire logic         in_skip_newlines,
  input  wire clt_pkg::cmd_t cmd,
  output clt_pkg::sts_t     sts,
  output logic [3:0]        out_token_kind,
  output logic [7:0]        out_lexeme_byte,
  output logic              out_lexeme_empty,
  output logic              out_last_byte,
  output logic              out_was_truncated,
  output logic [1:0]        out_string_error
);
  import clt_pkg::*;

  localparam int LW = $clog2(LEXEME_BYTES);
  localparam logic [LW-1:0] LEN_MAX = LW'(LEXEME_BYTES - 1);
  localparam logic [LW-1:0] GTGT_LEN = LW'((LEXEME_BYTES > 2) ? 2 : 1);
  localparam logic GTGT_TRUNC = (LEXEME_BYTES <= 2);

  typedef enum logic [8:0] {
    PH_IDLE    = 9'b000000001,
    PH_COMMENT = 9'b000000010,
    PH_GT      = 9'b000000100,
    PH_DASH    = 9'b000001000,
    PH_SYM     = 9'b000010000,
    PH_NUM     = 9'b000100000,
    PH_STR     = 9'b001000000,
    PH_ESC     = 9'b010000000,
    PH_OCT     = 9'b100000000
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [LW-1:0]   len_r;
  logic            ovf_r;
  logic [7:0]      quote_r, quote_nxt;
  logic [8:0]      oct_r, oct_nxt, oct_sum;
  logic [1:0]      dig_r, dig_nxt;
  logic [7:0]      char_r;
  logic            skip_r;

  logic [7:0]      cur;
  logic            app, app_ok, emit, consumed, direct;
  logic [7:0]      abyte, dbyte;
  logic [LW-1:0]   dlen, len_post;
  logic            dtrunc, ovf_post;
  kind_t           kind;
  serr_t           err;

  kind_t           em_kind_r;
  serr_t           em_err_r;
  logic [LW-1:0]   em_len_r;
  logic            em_trunc_r, em_direct_r;
  logic [7:0]      em_byte_r;
  logic [LW-1:0]   idx_r;

  logic            re;
  logic [LW-1:0]   raddr;
  logic [7:0]      rdata;

  assign cur     = cmd.sel_bs ? CH_BSL : char_r;
  assign oct_sum = {oct_r[5:0], 3'b000} + {6'b0, cur[2:0]};

  always_comb begin
    phase_nxt = phase_r;
    quote_nxt = quote_r;
    oct_nxt   = oct_r;
    dig_nxt   = dig_r;
    app       = 1'b0;
    abyte     = cur;
    emit      = 1'b0;
    direct    = 1'b0;
    dbyte     = cur;
    dlen      = LW'(1);
    dtrunc    = 1'b0;
    kind      = KIND_END;
    err       = SERR_NONE;
    consumed  = 1'b1;
    if (cmd.scan) begin
      case (phase_r)
        PH_COMMENT: begin
          if (cur == CH_NL) begin
            phase_nxt = PH_IDLE;
            consumed  = 1'b0;
          end
        end
        PH_GT: begin
          emit      = 1'b1;
          direct    = 1'b1;
          dbyte     = CH_GT;
          phase_nxt = PH_IDLE;
          if (cur == CH_GT) begin
            kind   = KIND_GTGT;
            dlen   = GTGT_LEN;
            dtrunc = GTGT_TRUNC;
          end else begin
            kind     = KIND_GT;
            consumed = 1'b0;
          end
        end
        PH_DASH: begin
          if (cur == CH_DOT || is_digit(cur)) begin
            app       = 1'b1;
            phase_nxt = PH_NUM;
          end else if (is_sym_more(cur)) begin
            app       = 1'b1;
            phase_nxt = PH_SYM;
          end else begin
            emit      = 1'b1;
            kind      = KIND_SYMBOL;
            phase_nxt = PH_IDLE;
            consumed  = 1'b0;
          end
        end
        PH_SYM: begin
          if (is_sym_more(cur)) begin
            app = 1'b1;
          end else begin
            emit      = 1'b1;
            kind      = KIND_SYMBOL;
            phase_nxt = PH_IDLE;
            consumed  = 1'b0;
          end
        end
        PH_NUM: begin
          if (is_num_more(cur)) begin
            app = 1'b1;
          end else begin
            emit      = 1'b1;
            kind      = KIND_NUMBER;
            phase_nxt = PH_IDLE;
            consumed  = 1'b0;
          end
        end
        PH_STR: begin
          if (cur == quote_r) begin
            emit      = 1'b1;
            kind      = KIND_STRING;
            phase_nxt = PH_IDLE;
          end else if (cur == CH_NL) begin
            emit      = 1'b1;
            kind      = KIND_STRING;
            err       = SERR_NEWLINE;
            phase_nxt = PH_IDLE;
            consumed  = 1'b0;
          end else if (cur == CH_BSL) begin
            phase_nxt = PH_ESC;
          end else begin
            app = 1'b1;
          end
        end
        PH_ESC: begin
          phase_nxt = PH_STR;
          if (is_octal(cur)) begin
            oct_nxt   = 9'(cur[2:0]);
            dig_nxt   = 2'd1;
            phase_nxt = PH_OCT;
          end else begin
            app = 1'b1;
            case (cur)
              CH_B:    abyte = CH_BS;
              CH_N:    abyte = CH_NL;
              CH_R:    abyte = CH_CR;
              CH_T:    abyte = CH_TAB;
              default: abyte = cur;
            endcase
          end
        end
        PH_OCT: begin
          if (is_octal(cur)) begin
            oct_nxt = oct_sum;
            dig_nxt = dig_r + 2'd1;
            if (dig_r == 2'd2) begin
              app       = 1'b1;
              abyte     = oct_sum[7:0];
              phase_nxt = PH_STR;
            end
          end else begin
            app       = 1'b1;
            abyte     = oct_r[7:0];
            phase_nxt = PH_STR;
            consumed  = 1'b0;
          end
        end
        default: begin
          // between tokens: length is already zero here
          if (cur == CH_NL) begin
            if (!skip_r) begin
              emit   = 1'b1;
              direct = 1'b1;
              kind   = KIND_NEWLINE;
            end
          end else if (is_space(cur)) begin
            phase_nxt = PH_IDLE;
          end else if (cur == CH_HASH) begin
            phase_nxt = PH_COMMENT;
          end else if (cur == CH_GT) begin
            phase_nxt = PH_GT;
          end else if (is_punct(cur)) begin
            emit   = 1'b1;
            direct = 1'b1;
            kind   = KIND_PUNCT;
          end else if (is_sym_first(cur)) begin
            app       = 1'b1;
            phase_nxt = PH_SYM;
          end else if (cur == CH_DASH) begin
            app       = 1'b1;
            phase_nxt = PH_DASH;
          end else if (is_digit(cur)) begin
            app       = 1'b1;
            phase_nxt = PH_NUM;
          end else if (cur == CH_DQ || cur == CH_SQ) begin
            quote_nxt = cur;
            phase_nxt = PH_STR;
          end else begin
            emit   = 1'b1;
            direct = 1'b1;
            kind   = KIND_INVALID;
          end
        end
      endcase
    end else if (cmd.fin) begin
      phase_nxt = PH_IDLE;
      case (phase_r)
        PH_GT: begin
          emit   = 1'b1;
          direct = 1'b1;
          dbyte  = CH_GT;
          kind   = KIND_GT;
        end
        PH_DASH, PH_SYM: begin
          emit = 1'b1;
          kind = KIND_SYMBOL;
        end
        PH_NUM: begin
          emit = 1'b1;
          kind = KIND_NUMBER;
        end
        PH_STR: begin
          emit = 1'b1;
          kind = KIND_STRING;
          err  = SERR_EOF;
        end
        PH_ESC: begin
          // escape cut short keeps its backslash
          app   = 1'b1;
          abyte = CH_BSL;
          emit  = 1'b1;
          kind  = KIND_STRING;
          err   = SERR_EOF;
        end
        PH_OCT: begin
          app   = 1'b1;
          abyte = oct_r[7:0];
          emit  = 1'b1;
          kind  = KIND_STRING;
          err   = SERR_EOF;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end else if (cmd.fin_end) begin
      emit   = 1'b1;
      direct = 1'b1;
      dlen   = '0;
      kind   = KIND_END;
    end
  end

  assign app_ok   = app && (len_r < LEN_MAX);
  assign len_post = len_r + LW'(app_ok);
  assign ovf_post = ovf_r | (app & ~app_ok);

  assign sts.consumed = consumed;
  assign sts.emit     = emit;
  assign sts.last     = (em_len_r == '0) || (idx_r == em_len_r - LW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      len_r   <= '0;
      ovf_r   <= 1'b0;
      quote_r <= '0;
      oct_r   <= '0;
      dig_r   <= '0;
    end else if (cmd.scan || cmd.fin || cmd.fin_end) begin
      phase_r <= phase_nxt;
      quote_r <= quote_nxt;
      oct_r   <= oct_nxt;
      dig_r   <= dig_nxt;
      len_r   <= emit ? '0 : len_post;
      ovf_r   <= emit ? 1'b0 : ovf_post;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      char_r <= in_char_in;
      skip_r <= in_skip_newlines;
    end
    if ((cmd.scan || cmd.fin || cmd.fin_end) && emit) begin
      em_kind_r   <= kind;
      em_err_r    <= err;
      em_direct_r <= direct;
      em_byte_r   <= dbyte;
      em_len_r    <= direct ? dlen : len_post;
      em_trunc_r  <= direct ? dtrunc : ovf_post;
    end
    if (cmd.rd_first) begin
      idx_r <= '0;
    end else if (cmd.rd_next) begin
      idx_r <= idx_r + LW'(1);
    end
  end

  assign re    = cmd.rd_first | cmd.rd_next;
  assign raddr = cmd.rd_first ? '0 : idx_r + LW'(1);

  clt_ram #(
    .WIDTH (8),
    .DEPTH (LEXEME_BYTES)
  ) u_lexeme_ram (
    .clk   (clk),
    .we    (app_ok),
    .waddr (len_r),
    .wdata (abyte),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_token_kind    = em_kind_r;
  assign out_string_error  = em_err_r;
  assign out_lexeme_empty  = (em_len_r == '0);
  assign out_last_byte     = sts.last;
  assign out_was_truncated = em_trunc_r;
  assign out_lexeme_byte   = (em_len_r == '0) ? 8'h00 : (em_direct_r ? em_byte_r : rdata);

  `CLT_ASSERT_IMPLY(a_idle_len_clear, phase_r == PH_IDLE, len_r == '0 && !ovf_r,
    "lexeme length left over between tokens")
  `CLT_ASSERT_IMPLY(a_no_write_on_read, cmd.rd_next || cmd.rd_first, !app_ok,
    "lexeme buffer written while being read out")

endmodule
`default_nettype wire

[src/clt_ctrl.sv]
// tokenizer controller: request decode, scan sequencing and output handshake
`default_nettype none
`include "command_line_tokenizer_macros.svh"
module clt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_char_in,
  input  wire logic          in_end_in,
  output logic               out_valid,
  input  wire logic          out_stall,
  output clt_pkg::cmd_t      cmd,
  input  wire clt_pkg::sts_t sts
);
  import clt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_FIN  = 6'b000100,
    S_END  = 6'b001000,
    S_ERD  = 6'b010000,
    S_SHOW = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   bs_r, bs_nxt;
  logic   q_bs_r, q_bs_nxt;
  logic   q_c_r, q_c_nxt;
  logic   q_fin_r, q_fin_nxt;
  logic   q_end_r, q_end_nxt;

  // pick the next piece of pending work
  function automatic state_t pick(input logic qb, input logic qc, input logic qf,
                                  input logic qe);
    state_t s;
    if (qb || qc) s = S_SCAN;
    else if (qf)  s = S_FIN;
    else if (qe)  s = S_END;
    else          s = S_IDLE;
    return s;
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_SHOW);

  always_comb begin
    state_nxt = state_r;
    bs_nxt    = bs_r;
    q_bs_nxt  = q_bs_r;
    q_c_nxt   = q_c_r;
    q_fin_nxt = q_fin_r;
    q_end_nxt = q_end_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_end_in) begin
            q_bs_nxt  = bs_r;
            q_fin_nxt = 1'b1;
            bs_nxt    = 1'b0;
          end else if (bs_r) begin
            // backslash-newline vanishes, otherwise the backslash is real
            bs_nxt   = (in_char_in == CH_BSL);
            q_bs_nxt = (in_char_in != CH_NL);
            q_c_nxt  = (in_char_in != CH_NL) && (in_char_in != CH_BSL);
          end else if (in_char_in == CH_BSL) begin
            bs_nxt = 1'b1;
          end else begin
            q_c_nxt = 1'b1;
          end
          state_nxt = pick(q_bs_nxt, q_c_nxt, q_fin_nxt, q_end_nxt);
        end
      end
      S_SCAN: begin
        cmd.scan   = 1'b1;
        cmd.sel_bs = q_bs_r;
        if (sts.consumed) begin
          if (q_bs_r) q_bs_nxt = 1'b0;
          else        q_c_nxt  = 1'b0;
        end
        state_nxt = sts.emit ? S_ERD : pick(q_bs_nxt, q_c_nxt, q_fin_nxt, q_end_nxt);
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        q_fin_nxt = 1'b0;
        q_end_nxt = 1'b1;
        state_nxt = sts.emit ? S_ERD : S_END;
      end
      S_END: begin
        cmd.fin_end = 1'b1;
        q_end_nxt   = 1'b0;
        state_nxt   = S_ERD;
      end
      S_ERD: begin
        cmd.rd_first = 1'b1;
        state_nxt    = S_SHOW;
      end
      S_SHOW: begin
        if (!out_stall) begin
          if (sts.last) begin
            state_nxt = pick(q_bs_r, q_c_r, q_fin_r, q_end_r);
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bs_r    <= 1'b0;
      q_bs_r  <= 1'b0;
      q_c_r   <= 1'b0;
      q_fin_r <= 1'b0;
      q_end_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bs_r    <= bs_nxt;
      q_bs_r  <= q_bs_nxt;
      q_c_r   <= q_c_nxt;
      q_fin_r <= q_fin_nxt;
      q_end_r <= q_end_nxt;
    end
  end

  `CLT_ASSERT_IMPLY(a_idle_no_work, state_r == S_IDLE,
    !(q_bs_r || q_c_r || q_fin_r || q_end_r), "work pending while idle")
  `CLT_ASSERT_NEXT(a_show_holds, state_r == S_SHOW && out_stall, state_r == S_SHOW,
    "result dropped while stalled")
  `CLT_ASSERT_IMPLY(a_end_after_fin, state_r == S_FIN, !q_bs_r && !q_c_r,
    "end of input handled before pending characters")

endmodule
`default_nettype wire

[src/command_line_tokenizer.sv]
// top level of the command line tokenizer
// Takes one character (or an end-of-input mark) per request and produces one result per
// lexeme byte when a token completes; an empty lexeme (end token) gives a single result.
// A request is taken while idle and then scanned; a character that closes a token is
// scanned again after the token goes out, and a backslash that turns out to be real adds
// a scan of its own. Each token starts a read of the lexeme memory and then reads its
// bytes out in order through the single read port; output stalls hold the readout.
// Lexemes keep at most LEXEME_BYTES-1 bytes and flag the rest as truncated. New requests
// are held off until all results of the current one have been taken.
`default_nettype none
module command_line_tokenizer #(
  parameter int LEXEME_BYTES = clt_pkg::LEXEME_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_in,
  input  wire logic       in_end_in,
  input  wire logic       in_skip_newlines,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [3:0]      out_token_kind,
  output logic [7:0]      out_lexeme_byte,
  output logic            out_lexeme_empty,
  output logic            out_last_byte,
  output logic            out_was_truncated,
  output logic [1:0]      out_string_error
);
  import clt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  clt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_char_in (in_char_in),
    .in_end_in  (in_end_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cmd        (cmd),
    .sts        (sts)
  );

  clt_dp #(
    .LEXEME_BYTES (LEXEME_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_char_in        (in_char_in),
    .in_skip_newlines  (in_skip_newlines),
    .cmd               (cmd),
    .sts               (sts),
    .out_token_kind    (out_token_kind),
    .out_lexeme_byte   (out_lexeme_byte),
    .out_lexeme_empty  (out_lexeme_empty),
    .out_last_byte     (out_last_byte),
    .out_was_truncated (out_was_truncated),
    .out_string_error  (out_string_error)
  );

endmodule
`default_nettype wire

[verif/tb_top.sv]
// self-checking testbench for the command line tokenizer
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import clt_pkg::*;

  localparam int LEXEME_BYTES = 32;
  localparam int MAXLEN = LEXEME_BYTES - 1;

  typedef enum int {
    SC_IDLE, SC_COMMENT, SC_GT, SC_DASH, SC_SYM, SC_NUM, SC_STR, SC_ESC, SC_OCT
  } scan_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic       skip_nl;
  } request_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] byte_val;
    logic       empty;
    logic       last;
    logic       trunc;
    serr_t      serr;
  } token_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_char_in = 8'h00;
  logic in_end_in = 1'b0;
  logic in_skip_newlines = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] out_token_kind;
  logic [7:0] out_lexeme_byte;
  logic out_lexeme_empty;
  logic out_last_byte;
  logic out_was_truncated;
  logic [1:0] out_string_error;

  command_line_tokenizer #(.LEXEME_BYTES(LEXEME_BYTES)) dut (.*);

  request_t    pending_requests[$];
  token_byte_t expected_bytes[$];
  int errors = 0;
  int tokens_seen = 0;
  int bytes_seen = 0;
  int requests_sent = 0;
  bit stimulus_done = 1'b0;
  bit hold_off = 1'b0;
  bit in_taken = 1'b0;

  // predictor state
  scan_t      sc_phase;
  logic [7:0] sc_buf[MAXLEN];
  int         sc_len;
  bit         sc_bsl;
  logic [7:0] sc_quote;
  logic [8:0] sc_oct;
  int         sc_oct_n;
  bit         sc_over;
  bit         sc_skip;

  function automatic bit sym_cont(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
           c == "_" || c == "$" || c == "/" || c == "*" || c == "?" || c == "-";
  endfunction

  function automatic void buf_add(logic [7:0] b);
    if (sc_len < MAXLEN) begin
      sc_buf[sc_len] = b;
      sc_len++;
    end else sc_over = 1'b1;
  endfunction

  function automatic void token_out(kind_t k, serr_t e);
    token_byte_t t;
    t.kind = k;
    t.trunc = sc_over;
    t.serr = e;
    if (sc_len == 0) begin
      t.byte_val = 8'h00;
      t.empty = 1'b1;
      t.last = 1'b1;
      expected_bytes.push_back(t);
    end else begin
      for (int i = 0; i < sc_len; i++) begin
        t.byte_val = sc_buf[i];
        t.empty = 1'b0;
        t.last = (i == sc_len - 1);
        expected_bytes.push_back(t);
      end
    end
    sc_len = 0;
    sc_over = 1'b0;
    sc_phase = SC_IDLE;
  endfunction

  function automatic void open_token(scan_t p, logic [7:0] c);
    sc_len = 0;
    sc_over = 1'b0;
    buf_add(c);
    sc_phase = p;
  endfunction

  function automatic void one_char(kind_t k, logic [7:0] c);
    open_token(SC_IDLE, c);
    token_out(k, SERR_NONE);
  endfunction

  function automatic void begin_token(logic [7:0] c);
    if (c == CH_NL) begin
      if (!sc_skip) one_char(KIND_NEWLINE, c);
    end else if (c == " " || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D) begin
    end else if (c == CH_HASH) sc_phase = SC_COMMENT;
    else if (c == CH_GT) sc_phase = SC_GT;
    else if (c == "|" || c == "." || c == "(" || c == ")" || c == "[" || c == "]" ||
             c == "{" || c == "}" || c == ":" || c == "," || c == "=")
      one_char(KIND_PUNCT, c);
    else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c == "$" ||
             c == "/" || c == "*" || c == "?")
      open_token(SC_SYM, c);
    else if (c == CH_DASH) open_token(SC_DASH, c);
    else if (c >= "0" && c <= "9") open_token(SC_NUM, c);
    else if (c == CH_DQ || c == CH_SQ) begin
      sc_quote = c;
      sc_len = 0;
      sc_over = 1'b0;
      sc_phase = SC_STR;
    end else one_char(KIND_INVALID, c);
  endfunction

  // scan one character; loops where the character must be looked at again
  function automatic void scan_char(logic [7:0] c);
    bit again;
    do begin
      again = 1'b0;
      case (sc_phase)
        SC_COMMENT:
          if (c == CH_NL) begin
            sc_phase = SC_IDLE;
            again = 1'b1;
          end
        SC_GT:
          if (c == CH_GT) begin
            open_token(SC_IDLE, CH_GT);
            buf_add(CH_GT);
            token_out(KIND_GTGT, SERR_NONE);
          end else begin
            one_char(KIND_GT, CH_GT);
            again = 1'b1;
          end
        SC_DASH:
          if (c == CH_DOT || (c >= "0" && c <= "9")) begin
            buf_add(c);
            sc_phase = SC_NUM;
          end else if (sym_cont(c)) begin
            buf_add(c);
            sc_phase = SC_SYM;
          end else begin
            token_out(KIND_SYMBOL, SERR_NONE);
            again = 1'b1;
          end
        SC_SYM:
          if (sym_cont(c)) buf_add(c);
          else begin
            token_out(KIND_SYMBOL, SERR_NONE);
            again = 1'b1;
          end
        SC_NUM:
          if ((c >= "0" && c <= "9") || c == "+" || c == "-" || c == "." || c == "e" ||
              c == "E")
            buf_add(c);
          else begin
            token_out(KIND_NUMBER, SERR_NONE);
            again = 1'b1;
          end
        SC_STR:
          if (c == sc_quote) token_out(KIND_STRING, SERR_NONE);
          else if (c == CH_NL) begin
            token_out(KIND_STRING, SERR_NEWLINE);
            again = 1'b1;
          end else if (c == CH_BSL) sc_phase = SC_ESC;
          else buf_add(c);
        SC_ESC: begin
          sc_phase = SC_STR;
          if (c == CH_B) buf_add(CH_BS);
          else if (c == CH_N) buf_add(CH_NL);
          else if (c == CH_R) buf_add(CH_CR);
          else if (c == CH_T) buf_add(CH_TAB);
          else if (c >= "0" && c <= "7") begin
            sc_oct = 9'(c - "0");
            sc_oct_n = 1;
            sc_phase = SC_OCT;
          end else buf_add(c);
        end
        SC_OCT:
          if (c >= "0" && c <= "7") begin
            sc_oct = {sc_oct[5:0], 3'b000} + 9'(c - "0");
            sc_oct_n++;
            if (sc_oct_n >= 3) begin
              buf_add(sc_oct[7:0]);
              sc_phase = SC_STR;
            end
          end else begin
            buf_add(sc_oct[7:0]);
            sc_phase = SC_STR;
            again = 1'b1;
          end
        default: begin
          sc_phase = SC_IDLE;
          begin_token(c);
        end
      endcase
    end while (again);
  endfunction

  function automatic void close_input();
    case (sc_phase)
      SC_GT: one_char(KIND_GT, CH_GT);
      SC_DASH, SC_SYM: token_out(KIND_SYMBOL, SERR_NONE);
      SC_NUM: token_out(KIND_NUMBER, SERR_NONE);
      SC_STR: token_out(KIND_STRING, SERR_EOF);
      SC_ESC: begin
        buf_add(CH_BSL);
        token_out(KIND_STRING, SERR_EOF);
      end
      SC_OCT: begin
        buf_add(sc_oct[7:0]);
        token_out(KIND_STRING, SERR_EOF);
      end
      default: ;
    endcase
    sc_phase = SC_IDLE;
    sc_len = 0;
    sc_over = 1'b0;
    token_out(KIND_END, SERR_NONE);
  endfunction

  function automatic void predict_request(request_t r);
    sc_skip = r.skip_nl;
    if (r.eoi) begin
      if (sc_bsl) begin
        sc_bsl = 1'b0;
        scan_char(CH_BSL);
      end
      close_input();
    end else if (sc_bsl) begin
      sc_bsl = 1'b0;
      if (r.ch != CH_NL) begin
        scan_char(CH_BSL);
        if (r.ch == CH_BSL) sc_bsl = 1'b1;
        else scan_char(r.ch);
      end
    end else if (r.ch == CH_BSL) sc_bsl = 1'b1;
    else scan_char(r.ch);
  endfunction

  // stimulus helpers
  function automatic void push_char(logic [7:0] c, bit skip = 1'b0);
    request_t r;
    r.ch = c;
    r.eoi = 1'b0;
    r.skip_nl = skip;
    pending_requests.push_back(r);
  endfunction

  function automatic void push_text(string s, bit skip = 1'b0);
    for (int i = 0; i < s.len(); i++) push_char(s[i], skip);
  endfunction

  function automatic void push_end(logic [7:0] junk = 8'hFF);
    request_t r;
    r.ch = junk;
    r.eoi = 1'b1;
    r.skip_nl = 1'b1;
    pending_requests.push_back(r);
  endfunction

  function automatic logic [7:0] pick_char();
    string alphabet = "aZ_$/*?-09.+eE \t#>|()[]{}:,=\"'\\\nbnrt7";
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(0, 255));
      1: return 8'h00;
      default: return alphabet[$urandom_range(0, alphabet.len() - 1)];
    endcase
  endfunction

  function automatic void push_random_line();
    int n;
    bit sk;
    n = $urandom_range(1, 12);
    sk = $urandom_range(0, 1);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: push_text("\"ab\\101\\tq\" ", sk);
        1: push_text("-3.5e+2 ", sk);
        2: push_text("sym_1-x ", sk);
        3: push_text(">> ", sk);
        4: push_text("\\\n", sk);
        default: push_char(pick_char(), sk);
      endcase
    end
    if ($urandom_range(0, 3) == 0) push_end(8'($urandom_range(0, 255)));
    else push_char(CH_NL, sk);
  endfunction

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // request driver
  int gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        in_taken = 1'b0;
        in_valid <= 1'b0;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
      end else if (!in_valid) begin
        if (gap > 0) gap--;
        else if (pending_requests.size() > 0) begin
          request_t r;
          r = pending_requests.pop_front();
          in_char_in <= r.ch;
          in_end_in <= r.eoi;
          in_skip_newlines <= r.skip_nl;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // requests are predicted when accepted
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      request_t r;
      r.ch = in_char_in;
      r.eoi = in_end_in;
      r.skip_nl = in_skip_newlines;
      predict_request(r);
      requests_sent++;
      in_taken = 1'b1;
    end
  end

  // receiver stall
  int stall_left = 0;
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (out_valid && $urandom_range(0, 2) == 0) stall_left = $urandom_range(0, 5);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      token_byte_t e;
      bytes_seen++;
      if (out_last_byte) tokens_seen++;
      if (expected_bytes.size() == 0) begin
        $error("unexpected result kind=%0d byte=%h", out_token_kind, out_lexeme_byte);
        errors++;
      end else begin
        e = expected_bytes.pop_front();
        if (out_token_kind != e.kind) begin
          $error("token_kind expected %0d actual %0d", e.kind, out_token_kind);
          errors++;
        end
        if (out_lexeme_byte != e.byte_val) begin
          $error("lexeme_byte expected %h actual %h", e.byte_val, out_lexeme_byte);
          errors++;
        end
        if (out_lexeme_empty != e.empty) begin
          $error("lexeme_empty expected %0d actual %0d", e.empty, out_lexeme_empty);
          errors++;
        end
        if (out_last_byte != e.last) begin
          $error("last_byte expected %0d actual %0d", e.last, out_last_byte);
          errors++;
        end
        if (out_was_truncated != e.trunc) begin
          $error("was_truncated expected %0d actual %0d", e.trunc, out_was_truncated);
          errors++;
        end
        if (out_string_error != e.serr) begin
          $error("string_error expected %0d actual %0d", e.serr, out_string_error);
          errors++;
        end
      end
    end
  end

  initial begin
    string long_sym;
    int wait_cycles;
    sc_phase = SC_IDLE;
    sc_len = 0;
    sc_bsl = 1'b0;
    sc_quote = 8'h00;
    sc_oct = 9'd0;
    sc_oct_n = 0;
    sc_over = 1'b0;
    sc_skip = 1'b0;
    long_sym = "";
    for (int i = 0; i < 40; i++) long_sym = {long_sym, "x"};

    // directed part
    push_text("a>b>>|-x -.5 9e+1 # c\n");
    push_char(8'h00);
    push_char(8'hFF);
    push_text("\"\\b\\n\\r\\t\\0\\777\\18q'\\\n\"");
    push_text("'open\n", 1'b1);
    push_text("\"tail\\");
    push_end(8'h00);
    push_text("- \\\\ \\");
    push_end();
    push_text({long_sym, " "});
    push_text("\"\\12");
    push_end();
    push_char(">");
    push_end();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // long receiver hold while requests keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none

    while (pending_requests.size() < 400) push_random_line();
    push_end();

    wait (pending_requests.size() == 0 && !in_valid);
    wait_cycles = 0;
    while (expected_bytes.size() > 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (50) @(posedge clk);
    $display("requests %0d, tokens %0d, result bytes %0d", requests_sent, tokens_seen,
             bytes_seen);
    $display("covered every token kind, escapes, continuations and truncation");
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

[command_line_tokenizer.f]
+incdir+src
src/clt_pkg.sv
src/clt_ram.sv
src/clt_dp.sv
src/clt_ctrl.sv
src/command_line_tokenizer.sv
verif/tb_top.sv
